// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property on a clock with a synchronous reset that masks it.
`define WSD_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Checked property that also holds during reset.
`define WSD_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== rtl/wsd_pkg.sv =====
`default_nettype none

package wsd_pkg;

  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [1:0] {
    EV_PAYLOAD     = 2'd0,
    EV_EMPTY       = 2'd1,
    EV_CLOSE       = 2'd2,
    EV_UNSUPPORTED = 2'd3
  } ev_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DROP    = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  // One classified beat handed from the parser to the output side.
  typedef struct packed {
    ev_kind_t    kind;
    logic [7:0]  data;
    logic [7:0]  key;
    logic        last;
    logic [3:0]  opcode;
    logic        fin;
  } wsd_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/wsd_front.sv =====
`default_nettype none

`include "assert_macros.svh"

module wsd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire logic [7:0]      rx_byte,
  input  wire logic            chunk_start,
  output logic                 push,
  output wsd_pkg::wsd_cmd_t    cmd
);

  wsd_pkg::phase_t phase, phase_next;
  logic [1:0]  hdr_idx, hdr_idx_next;
  logic [3:0]  opcode, opcode_next;
  logic        fin, fin_next;
  logic        masked, masked_next;
  logic [15:0] plen, plen_next;
  logic [15:0] done_cnt, done_cnt_next;
  logic [31:0] key, key_next;

  logic [15:0] done_inc;
  logic [7:0]  key_byte;
  logic        emit;

  assign done_inc = done_cnt + 16'd1;

  always_comb begin
    unique case (done_cnt[1:0])
      2'd0:    key_byte = key[31:24];
      2'd1:    key_byte = key[23:16];
      2'd2:    key_byte = key[15:8];
      default: key_byte = key[7:0];
    endcase
  end

  // Next state
  always_comb begin
    phase_next    = phase;
    hdr_idx_next  = hdr_idx;
    opcode_next   = opcode;
    fin_next      = fin;
    masked_next   = masked;
    plen_next     = plen;
    done_cnt_next = done_cnt;
    key_next      = key;
    if (chunk_start) begin
      fin_next      = rx_byte[7];
      opcode_next   = rx_byte[3:0];
      masked_next   = 1'b0;
      plen_next     = 16'd0;
      done_cnt_next = 16'd0;
      key_next      = 32'd0;
      hdr_idx_next  = 2'd0;
      phase_next    = (rx_byte[3:0] == wsd_pkg::OP_CLOSE) ? wsd_pkg::PH_DONE
                                                          : wsd_pkg::PH_HDR1;
    end else begin
      unique case (phase)
        wsd_pkg::PH_HDR1: begin
          masked_next = rx_byte[7];
          if (rx_byte[6:0] == wsd_pkg::LEN_EXT64) begin
            phase_next = wsd_pkg::PH_DONE;
          end else if (rx_byte[6:0] == wsd_pkg::LEN_EXT16) begin
            plen_next    = 16'd0;
            hdr_idx_next = 2'd0;
            phase_next   = wsd_pkg::PH_EXTLEN;
          end else begin
            plen_next    = {9'd0, rx_byte[6:0]};
            hdr_idx_next = 2'd0;
            if (rx_byte[7])                  phase_next = wsd_pkg::PH_MASK;
            else if (rx_byte[6:0] == 7'd0)   phase_next = wsd_pkg::PH_DONE;
            else                             phase_next = wsd_pkg::PH_DROP;
          end
        end
        wsd_pkg::PH_EXTLEN: begin
          plen_next    = {plen[7:0], rx_byte};
          hdr_idx_next = hdr_idx + 2'd1;
          if (hdr_idx == 2'd1) begin
            hdr_idx_next = 2'd0;
            if (masked)                        phase_next = wsd_pkg::PH_MASK;
            else if ({plen[7:0], rx_byte} == 16'd0) phase_next = wsd_pkg::PH_DONE;
            else                               phase_next = wsd_pkg::PH_DROP;
          end
        end
        wsd_pkg::PH_MASK: begin
          key_next     = {key[23:0], rx_byte};
          hdr_idx_next = hdr_idx + 2'd1;
          if (hdr_idx == 2'd3) begin
            done_cnt_next = 16'd0;
            phase_next    = (plen == 16'd0) ? wsd_pkg::PH_DONE : wsd_pkg::PH_PAYLOAD;
          end
        end
        wsd_pkg::PH_PAYLOAD, wsd_pkg::PH_DROP: begin
          done_cnt_next = done_inc;
          if (done_inc == plen) phase_next = wsd_pkg::PH_DONE;
        end
        default: ;
      endcase
    end
  end

  // Outputs
  always_comb begin
    emit        = 1'b0;
    cmd.kind    = wsd_pkg::EV_PAYLOAD;
    cmd.data    = 8'd0;
    cmd.key     = 8'd0;
    cmd.last    = 1'b1;
    cmd.opcode  = opcode_next;
    cmd.fin     = fin_next;
    if (chunk_start) begin
      if (rx_byte[3:0] == wsd_pkg::OP_CLOSE) begin
        emit     = 1'b1;
        cmd.kind = wsd_pkg::EV_CLOSE;
      end
    end else begin
      unique case (phase)
        wsd_pkg::PH_HDR1: begin
          if (rx_byte[6:0] == wsd_pkg::LEN_EXT64) begin
            emit     = 1'b1;
            cmd.kind = wsd_pkg::EV_UNSUPPORTED;
          end
        end
        wsd_pkg::PH_MASK: begin
          if (hdr_idx == 2'd3 && plen == 16'd0) begin
            emit     = 1'b1;
            cmd.kind = wsd_pkg::EV_EMPTY;
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          emit     = 1'b1;
          cmd.data = rx_byte;
          cmd.key  = key_byte;
          cmd.last = (done_inc == plen);
        end
        default: ;
      endcase
    end
  end

  assign push = fire & emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= wsd_pkg::PH_IDLE;
      hdr_idx  <= 2'd0;
      opcode   <= 4'd0;
      fin      <= 1'b0;
      masked   <= 1'b0;
      plen     <= 16'd0;
      done_cnt <= 16'd0;
      key      <= 32'd0;
    end else if (fire) begin
      phase    <= phase_next;
      hdr_idx  <= hdr_idx_next;
      opcode   <= opcode_next;
      fin      <= fin_next;
      masked   <= masked_next;
      plen     <= plen_next;
      done_cnt <= done_cnt_next;
      key      <= key_next;
    end
  end

  `WSD_ASSERT(a_idle_silent, clk, rst, fire && !chunk_start && (phase == wsd_pkg::PH_IDLE || phase == wsd_pkg::PH_DONE) |-> !push, "beat pushed while idle")
  `WSD_ASSERT(a_close_done, clk, rst, push && cmd.kind == wsd_pkg::EV_CLOSE |=> phase == wsd_pkg::PH_DONE, "close did not end frame")
  `WSD_ASSERT(a_last_ends, clk, rst, push && cmd.last |=> phase == wsd_pkg::PH_DONE, "last result without frame end")

endmodule

`default_nettype wire

// ===== rtl/wsd_queue.sv =====
`default_nettype none

`include "assert_macros.svh"

module wsd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire wsd_pkg::wsd_cmd_t wr_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   rd_valid,
  output wsd_pkg::wsd_cmd_t      rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  wsd_pkg::wsd_cmd_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_push  = push & ~full;
  assign do_pop   = pop & rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  `WSD_ASSERT_ALWAYS(a_count_range, clk, rst || count <= CNT_W'(DEPTH), "queue count overflow")
  `WSD_ASSERT(a_no_push_full, clk, rst, full |-> !push, "push into full queue")

endmodule

`default_nettype wire

// ===== rtl/wsd_back.sv =====
`default_nettype none

`include "assert_macros.svh"

module wsd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire wsd_pkg::wsd_cmd_t q_data,
  output logic                   pop,
  output logic                   m_valid,
  input  wire logic              m_ready,
  output logic [15:0]            m_data,
  output logic [1:0]             m_kind,
  output logic                   m_last
);

  logic [7:0] payload;
  logic [3:0] opcode;
  logic       fin;

  // Refill the output register when it is empty or being drained.
  assign pop = q_valid & (~m_valid | m_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (!m_valid || m_ready) begin
      m_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      payload <= q_data.data ^ q_data.key;
      m_kind  <= q_data.kind;
      m_last  <= q_data.last;
      opcode  <= q_data.opcode;
      fin     <= q_data.fin;
    end
  end

  assign m_data = {3'd0, fin, opcode, payload};

  `WSD_ASSERT(a_fill, clk, rst, q_valid && !m_valid |=> m_valid, "output register not filled")

endmodule

`default_nettype wire

// ===== rtl/websocket_frame_deframer_unmask_top.sv =====
// Channel   Dir  tdata                               tuser            tlast
// s_axis    in   [7:0] rx_byte                        [0] chunk_start  -
// m_axis    out  [7:0] payload, [11:8] opcode, [12]   [1:0] kind       byte_last
//                fin, [15:13] zero
//
// One beat per cycle while s_axis_tready is high; the parser classifies each byte
// in the cycle it is accepted, and results then pass the queue and output register.
// The header parser and the output register are parted by a small queue;
// s_axis_tready drops only when that queue is full under output backpressure.
// rst is synchronous, active high; it returns the parser to idle and empties
// the queue and output register.
`default_nettype none

module websocket_frame_deframer_unmask_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] chunk_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] payload_byte, [11:8] frame_opcode, [12] frame_fin
  output logic [1:0]       m_axis_tuser,   // [1:0] event_kind
  output logic             m_axis_tlast
);

  logic              fire, push, full, pop, q_valid;
  wsd_pkg::wsd_cmd_t cmd, q_data;

  assign s_axis_tready = ~full;
  assign fire          = s_axis_tvalid & s_axis_tready;

  wsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .rx_byte     (s_axis_tdata),
    .chunk_start (s_axis_tuser),
    .push        (push),
    .cmd         (cmd)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (cmd),
    .full     (full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  wsd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (m_axis_tdata),
    .m_kind  (m_axis_tuser),
    .m_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire
